// ----- rtl/core/prime_with_fibonacci_digit_sum_check_core_defines.svh -----
// assertion helpers for the prime / digit sum classifier
`ifndef PRIME_WITH_FIBONACCI_DIGIT_SUM_CHECK_CORE_DEFINES_SVH
`define PRIME_WITH_FIBONACCI_DIGIT_SUM_CHECK_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PWF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pwfdsc_pkg.sv -----
`default_nettype none

package pwfdsc_pkg;

    // default working width of the classified value
    localparam int PWF_WIDTH = 32;

    // request field widths
    localparam int VALUE_W = 32;

    // result field widths and tdata packing
    localparam int TOTAL_W      = 7;
    localparam int OUT_FIELDS_W = 1 + TOTAL_W + 1 + 1;
    localparam int OUT_TDATA_W  = 16;

    // arithmetic constants
    localparam int RADIX         = 10;
    localparam int DIGIT_W       = $clog2(RADIX);
    localparam int FIRST_DIVISOR = 2;

endpackage

`default_nettype wire

// ----- rtl/core/prime_with_fibonacci_digit_sum_check_core.sv -----
`default_nettype none

// Classifies one signed value per request: whether it is prime (trial division
// by 2, 3, ... while d*d <= value), its decimal digit sum (0 when the value is
// not positive), whether that sum is a Fibonacci number, and whether both hold.
// Only the low WIDTH bits of the value are used, sign-extended from bit WIDTH-1;
// above 32 the value is zero-extended and always non-negative. A single
// restoring divider, one quotient bit per cycle, does all the division: it
// divides by 10 to peel off digits, then by each trial divisor, with one
// bookkeeping step after each division. A request therefore runs the digit
// divisions, then the trial divisions, then a Fibonacci walk, and then posts
// its result once the output register is free; values that are not positive
// skip the divider and go straight to the Fibonacci walk, and a large prime at
// WIDTH = 32 needs about 46341 divisors. One request is worked on at a time;
// the result sits in an output register, so the next request is taken as soon
// as the previous result has been posted, even while it still waits on tready.
module prime_with_fibonacci_digit_sum_check_core #(
    parameter int WIDTH = pwfdsc_pkg::PWF_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [pwfdsc_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value
    // result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] is_prime, [7:1] digit_total, [8] total_is_fibonacci, [9] selected,
    // [15:10] zero
    output logic [pwfdsc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import pwfdsc_pkg::*;

`include "prime_with_fibonacci_digit_sum_check_core_defines.svh"

    // bound on the digit count and digit sum of a WIDTH-bit value
    localparam int DIGITS  = (WIDTH * 31) / 100 + 1;
    localparam int SUM_MAX = 9 * DIGITS;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int FIB_W   = SUM_W + 2;
    localparam int CNT_W   = $clog2(WIDTH);
    localparam int PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,   // waiting for a request
        ST_DSUM  = 6'b000010,   // dividing by ten
        ST_DSTEP = 6'b000100,   // collect one digit
        ST_PRIME = 6'b001000,   // dividing by the trial divisor
        ST_PSTEP = 6'b010000,   // check quotient and remainder
        ST_FIB   = 6'b100000    // walk the Fibonacci sequence
    } state_t;

    state_t             state_reg, state_next;

    // shared divider
    logic [WIDTH-1:0]   n_reg, n_next;     // positive value under test
    logic [WIDTH-1:0]   w_reg, w_next;     // dividend shifting out, quotient in
    logic [WIDTH-1:0]   rem_reg, rem_next;
    logic [WIDTH-1:0]   d_reg, d_next;     // divisor
    logic [CNT_W-1:0]   cnt_reg, cnt_next; // bit position

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               prime_reg, prime_next;
    logic [FIB_W-1:0]   fa_reg, fa_next;
    logic [FIB_W-1:0]   fb_reg, fb_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic               o_prime_reg, o_prime_next;
    logic [TOTAL_W-1:0] o_total_reg, o_total_next;
    logic               o_fib_reg, o_fib_next;
    logic               o_sel_reg, o_sel_next;

    // request decode
    logic [VALUE_W+WIDTH-1:0] ext_value;
    logic [WIDTH-1:0]         raw;
    logic                     positive;
    logic                     accept;

    // divider step
    logic [WIDTH:0]           trial;
    logic [WIDTH:0]           trial_diff;
    logic                     trial_ge;
    logic                     last_bit;

    logic [FIB_W-1:0]         sum_ext;
    logic [SUM_W+TOTAL_W-1:0] total_ext;
    logic                     fib_done;
    logic                     out_free;

    // low WIDTH bits, zero-extended when WIDTH is above the field width
    assign ext_value = {{WIDTH{1'b0}}, s_tdata};
    assign raw       = ext_value[WIDTH-1:0];
    assign positive  = !raw[WIDTH-1] && (raw != '0);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign trial      = {rem_reg, w_reg[WIDTH-1]};
    assign trial_diff = trial - {1'b0, d_reg};
    assign trial_ge   = (trial >= {1'b0, d_reg});
    assign last_bit   = (cnt_reg == CNT_W'(WIDTH - 1));

    assign sum_ext   = FIB_W'(sum_reg);
    assign total_ext = {{TOTAL_W{1'b0}}, sum_reg};
    assign fib_done  = !(fa_reg < sum_ext);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        w_next        = w_reg;
        rem_next      = rem_reg;
        d_next        = d_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        prime_next    = prime_reg;
        fa_next       = fa_reg;
        fb_next       = fb_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        o_prime_next  = o_prime_reg;
        o_total_next  = o_total_reg;
        o_fib_next    = o_fib_reg;
        o_sel_next    = o_sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sum_next   = '0;
                    prime_next = 1'b0;
                    if (positive)
                    begin
                        n_next     = raw;
                        w_next     = raw;
                        rem_next   = '0;
                        d_next     = WIDTH'(RADIX);
                        cnt_next   = '0;
                        state_next = ST_DSUM;
                    end
                    else
                    begin
                        // not positive: not prime, digit sum zero
                        fa_next    = '0;
                        fb_next    = FIB_W'(1);
                        state_next = ST_FIB;
                    end
                end
            end

            ST_DSUM, ST_PRIME:
            begin
                rem_next = trial_ge ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
                w_next   = {w_reg[WIDTH-2:0], trial_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_bit)
                begin
                    state_next = (state_reg == ST_DSUM) ? ST_DSTEP : ST_PSTEP;
                end
            end

            ST_DSTEP:
            begin
                sum_next = sum_reg + SUM_W'(rem_reg[DIGIT_W-1:0]);
                rem_next = '0;
                cnt_next = '0;
                if (w_reg != '0)
                begin
                    // quotient becomes the next dividend
                    state_next = ST_DSUM;
                end
                else if (n_reg < WIDTH'(FIRST_DIVISOR))
                begin
                    prime_next = 1'b0;
                    fa_next    = '0;
                    fb_next    = FIB_W'(1);
                    state_next = ST_FIB;
                end
                else
                begin
                    w_next     = n_reg;
                    d_next     = WIDTH'(FIRST_DIVISOR);
                    state_next = ST_PRIME;
                end
            end

            ST_PSTEP:
            begin
                priority if (d_reg > w_reg)
                begin
                    // d*d > n: no divisor found
                    prime_next = 1'b1;
                    fa_next    = '0;
                    fb_next    = FIB_W'(1);
                    state_next = ST_FIB;
                end
                else if (rem_reg == '0)
                begin
                    prime_next = 1'b0;
                    fa_next    = '0;
                    fb_next    = FIB_W'(1);
                    state_next = ST_FIB;
                end
                else
                begin
                    d_next     = d_reg + WIDTH'(1);
                    w_next     = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_PRIME;
                end
            end

            ST_FIB:
            begin
                if (!fib_done)
                begin
                    fa_next = fb_reg;
                    fb_next = fa_reg + fb_reg;
                end
                else if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    o_prime_next  = prime_reg;
                    o_total_next  = total_ext[TOTAL_W-1:0];
                    o_fib_next    = (fa_reg == sum_ext);
                    o_sel_next    = prime_reg && (fa_reg == sum_ext);
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        w_reg       <= w_next;
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        cnt_reg     <= cnt_next;
        sum_reg     <= sum_next;
        prime_reg   <= prime_next;
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        o_prime_reg <= o_prime_next;
        o_total_reg <= o_total_next;
        o_fib_reg   <= o_fib_next;
        o_sel_reg   <= o_sel_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, o_sel_reg, o_fib_reg, o_total_reg, o_prime_reg};

    // divider remainder always stays below the divisor
    `PWF_ASSERT_NOW(a_rem_below_divisor,
        (state_reg == ST_DSUM) || (state_reg == ST_PRIME) || (state_reg == ST_PSTEP),
        rem_reg < d_reg, "divider remainder not below divisor")

    // a collected digit is a decimal digit
    `PWF_ASSERT_NOW(a_digit_range, state_reg == ST_DSTEP,
        rem_reg < WIDTH'(RADIX), "digit out of range")

    // a request that is not positive skips straight to the Fibonacci walk
    `PWF_ASSERT_NEXT(a_nonpos_shortcut, accept && !positive,
        (state_reg == ST_FIB) && (sum_reg == '0) && !prime_reg,
        "non-positive request did not short-cut")

    // posted result flags agree with each other
    `PWF_ASSERT_NOW(a_selected_consistent, m_tvalid_reg,
        o_sel_reg == (o_prime_reg && o_fib_reg), "selected flag inconsistent")

endmodule

`default_nettype wire
